// ----- sv/lobm_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the limit order book matcher.
// No dependencies.
package lobm_pkg;
	localparam int unsigned PRICE_LEVELS_DEF      = 4096;
	localparam int unsigned LEVEL_QUEUE_DEPTH_DEF = 16;
	localparam int unsigned MAX_FILLS_DEF         = 63;

	typedef enum logic [2:0] {
		DISP_FILLED = 3'd0,
		DISP_RESTED = 3'd1,
		DISP_BAD    = 3'd2,
		DISP_FULL   = 3'd3,
		DISP_CAP    = 3'd4
	} disp_t;

	localparam logic KIND_FILL = 1'b0;
	localparam logic KIND_DONE = 1'b1;
endpackage

// ----- sv/limit_order_book_matcher.sv -----
`timescale 1ns / 1ps
// Price-time priority order book matcher. Takes one order at a time and holds
// s_tready low until that order's done item is taken. A check state examines
// each new order. Each fill passes through a level read, a volume read and a
// compare and subtract with write back before its result, then waits on
// m_tready, and a next state picks the next step; a fill that empties its level
// adds a scan that skips any further empty levels. Resting a remainder passes
// through a level read, a table fetch and a queue push before its done item; a
// rejected or zero-volume order goes to its done item straight from the check.
// Every done item then waits on m_tready before the block returns to idle.
// Reset clears the level tables with a sweep, during which no order is taken.
// Prices are held one bit wider than the level index so that "none" markers
// (-1 for bids, PRICE_LEVELS for asks) fit.
module limit_order_book_matcher import lobm_pkg::*; #(
	parameter int unsigned PRICE_LEVELS      = PRICE_LEVELS_DEF,
	parameter int unsigned LEVEL_QUEUE_DEPTH = LEVEL_QUEUE_DEPTH_DEF,
	parameter int unsigned MAX_FILLS         = MAX_FILLS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // [0] side, [16:1] limit_price, [48:17] quantity
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // [15:0] fill_price, [47:16] fill_quantity, [50:48] disposition
	output logic        m_tuser,  // item_kind
	output logic        m_tlast
);
	localparam int unsigned LW = (PRICE_LEVELS > 1) ? $clog2(PRICE_LEVELS) : 1;
	localparam int unsigned PW = LW + 1;
	localparam int unsigned QW = (LEVEL_QUEUE_DEPTH > 1) ? $clog2(LEVEL_QUEUE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(LEVEL_QUEUE_DEPTH + 1);
	localparam int unsigned SW = CW + 1;
	localparam int unsigned AW = LW + QW;
	localparam int unsigned FW = $clog2(MAX_FILLS + 1);
	localparam logic [PW-1:0] NO_BID = '1;
	localparam logic [PW-1:0] NO_ASK = PW'(PRICE_LEVELS);

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_CHECK, ST_LVLRD, ST_VOLRD, ST_FILL, ST_FOUT,
		ST_SCAN, ST_NEXT, ST_REST, ST_OUT
	} state_t;

	state_t        state_q;
	logic [LW-1:0] clr_q;
	logic          sell_q;
	logic [15:0]   price_q;
	logic [31:0]   rem_q;
	logic [PW-1:0] bid_q, ask_q, cur_q;
	logic [FW-1:0] nfill_q;
	logic [QW-1:0] head_q;
	logic [CW-1:0] cnt_q;
	logic          rest_q;
	logic          left_q;

	// level tables and volume memory
	logic [QW-1:0] head_mem [PRICE_LEVELS];
	logic [CW-1:0] cnt_mem  [PRICE_LEVELS];
	logic [31:0]   vol_mem  [2**AW];
	logic [QW-1:0] head_rd_q;
	logic [CW-1:0] cnt_rd_q;
	logic [31:0]   vol_rd_q;

	logic          lvl_we;
	logic [LW-1:0] lvl_wa, lvl_ra;
	logic [QW-1:0] lvl_wh;
	logic [CW-1:0] lvl_wc;
	logic          vol_we;
	logic [AW-1:0] vol_wa, vol_ra;
	logic [31:0]   vol_wd;

	always_ff @(posedge clk) begin
		if (lvl_we) begin
			head_mem[lvl_wa] <= lvl_wh;
			cnt_mem[lvl_wa]  <= lvl_wc;
		end
		head_rd_q <= head_mem[lvl_ra];
		cnt_rd_q  <= cnt_mem[lvl_ra];
		if (vol_we) vol_mem[vol_wa] <= vol_wd;
		vol_rd_q <= vol_mem[vol_ra];
	end

	// scan unit walks empty levels
	logic          scan_start, scan_busy;
	logic [PW-1:0] scan_cur, scan_from, scan_edge, scan_addr;
	logic          scan_empty;
	lobm_scan #(.PW(PW)) u_scan (
		.clk(clk), .arst_n(arst_n), .start(scan_start), .down(sell_q),
		.from(scan_from), .level_empty(scan_empty), .edge_val(scan_edge),
		.addr(scan_addr), .cur(scan_cur), .busy(scan_busy)
	);

	logic [31:0]   fill_amt;
	logic          level_pop;
	logic [QW-1:0] head_nx;
	logic [SW-1:0] tail_sum;
	logic [QW-1:0] tail_slot;
	logic          has_room;
	logic [PW-1:0] p_ext;
	logic          crossing;
	logic          cur_ok;

	assign p_ext     = PW'(price_q[LW-1:0]);
	assign fill_amt  = (rem_q < vol_rd_q) ? rem_q : vol_rd_q;
	assign level_pop = (fill_amt == vol_rd_q);
	assign head_nx   = (head_q == QW'(LEVEL_QUEUE_DEPTH - 1)) ? '0 : head_q + QW'(1);
	assign tail_sum  = SW'(head_q) + SW'(cnt_q);
	assign tail_slot = (tail_sum >= SW'(LEVEL_QUEUE_DEPTH)) ?
		QW'(tail_sum - SW'(LEVEL_QUEUE_DEPTH)) : QW'(tail_sum);
	assign has_room  = (cnt_q < CW'(LEVEL_QUEUE_DEPTH));
	assign crossing  = sell_q ? (bid_q != NO_BID && p_ext <= bid_q) : (p_ext >= ask_q);
	// walk continues while cur is on the crossing side of the limit
	assign cur_ok    = sell_q ? (cur_q != NO_BID && cur_q >= p_ext) : (cur_q <= p_ext);

	assign scan_start = (state_q == ST_FOUT) && m_tready && !left_q;
	assign scan_from  = sell_q ? cur_q - PW'(1) : cur_q + PW'(1);
	assign scan_edge  = sell_q ? NO_BID : NO_ASK;
	assign scan_empty = (cnt_rd_q == '0);

	always_comb begin
		lvl_we = 1'b0;
		lvl_wa = cur_q[LW-1:0];
		lvl_wh = head_q;
		lvl_wc = cnt_q;
		lvl_ra = cur_q[LW-1:0];
		vol_we = 1'b0;
		vol_wa = {cur_q[LW-1:0], head_q};
		vol_wd = vol_rd_q - fill_amt;
		vol_ra = {cur_q[LW-1:0], head_rd_q};
		case (state_q)
			ST_CLEAR: begin
				lvl_we = 1'b1; lvl_wa = clr_q; lvl_wh = '0; lvl_wc = '0;
			end
			ST_SCAN: lvl_ra = scan_addr[LW-1:0];
			ST_FILL: begin
				vol_we = 1'b1;
				if (level_pop) begin
					lvl_we = 1'b1;
					lvl_wh = head_nx;
					lvl_wc = cnt_q - CW'(1);
				end
			end
			ST_REST: begin
				vol_wa = {cur_q[LW-1:0], tail_slot};
				vol_wd = rem_q;
				vol_we = has_room;
				lvl_wc = cnt_q + CW'(1);
				lvl_we = has_room;
			end
			default: ;
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			bid_q    <= NO_BID;
			ask_q    <= NO_ASK;
			sell_q   <= 1'b0;
			price_q  <= '0;
			rem_q    <= '0;
			cur_q    <= '0;
			nfill_q  <= '0;
			head_q   <= '0;
			cnt_q    <= '0;
			rest_q   <= 1'b0;
			left_q   <= 1'b0;
			m_tvalid <= 1'b0;
			m_tuser  <= KIND_FILL;
			m_tlast  <= 1'b0;
			m_tdata  <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + LW'(1);
					if (clr_q == LW'(PRICE_LEVELS - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: if (s_tvalid) begin
					sell_q  <= s_tdata[0];
					price_q <= s_tdata[16:1];
					rem_q   <= s_tdata[48:17];
					nfill_q <= '0;
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (32'(price_q) >= PRICE_LEVELS) begin
						m_tdata <= {5'd0, DISP_BAD, rem_q, price_q};
						m_tuser <= KIND_DONE; m_tlast <= 1'b1; m_tvalid <= 1'b1;
						state_q <= ST_OUT;
					end else if (rem_q == '0) begin
						m_tdata <= {5'd0, DISP_FILLED, 32'd0, price_q};
						m_tuser <= KIND_DONE; m_tlast <= 1'b1; m_tvalid <= 1'b1;
						state_q <= ST_OUT;
					end else if (crossing) begin
						cur_q   <= sell_q ? bid_q : ask_q;
						rest_q  <= 1'b0;
						state_q <= ST_LVLRD;
					end else begin
						cur_q   <= p_ext;
						rest_q  <= 1'b1;
						state_q <= ST_LVLRD;
					end
				end
				ST_LVLRD: state_q <= ST_VOLRD;
				ST_VOLRD: begin
					head_q  <= head_rd_q;
					cnt_q   <= cnt_rd_q;
					state_q <= rest_q ? ST_REST : ST_FILL;
				end
				ST_FILL: begin
					m_tdata <= {5'd0, DISP_FILLED, fill_amt, 16'(cur_q)};
					m_tuser <= KIND_FILL; m_tlast <= 1'b0; m_tvalid <= 1'b1;
					rem_q   <= rem_q - fill_amt;
					nfill_q <= nfill_q + FW'(1);
					left_q  <= !level_pop || (cnt_q != CW'(1));
					state_q <= ST_FOUT;
				end
				ST_FOUT: if (m_tready) begin
					m_tvalid <= 1'b0;
					// an emptied level hands over to the scan
					state_q  <= left_q ? ST_NEXT : ST_SCAN;
				end
				ST_SCAN: if (!scan_busy) begin
					cur_q   <= scan_cur;
					state_q <= ST_NEXT;
				end
				ST_NEXT: begin
					if (sell_q) bid_q <= cur_q; else ask_q <= cur_q;
					if (rem_q != '0 && cur_ok) begin
						if (32'(nfill_q) < MAX_FILLS) state_q <= ST_LVLRD;
						else begin
							m_tdata <= {5'd0, DISP_CAP, rem_q, price_q};
							m_tuser <= KIND_DONE; m_tlast <= 1'b1; m_tvalid <= 1'b1;
							state_q <= ST_OUT;
						end
					end else if (rem_q == '0) begin
						m_tdata <= {5'd0, DISP_FILLED, 32'd0, price_q};
						m_tuser <= KIND_DONE; m_tlast <= 1'b1; m_tvalid <= 1'b1;
						state_q <= ST_OUT;
					end else begin
						// rest what is left at the order's own level
						cur_q   <= p_ext;
						rest_q  <= 1'b1;
						state_q <= ST_LVLRD;
					end
				end
				ST_REST: begin
					m_tuser <= KIND_DONE; m_tlast <= 1'b1; m_tvalid <= 1'b1;
					state_q <= ST_OUT;
					if (has_room) begin
						m_tdata <= {5'd0, DISP_RESTED, rem_q, price_q};
						if (!sell_q && (bid_q == NO_BID || p_ext > bid_q)) bid_q <= p_ext;
						if (sell_q && p_ext < ask_q) ask_q <= p_ext;
					end else begin
						m_tdata <= {5'd0, DISP_FULL, rem_q, price_q};
					end
				end
				ST_OUT: if (m_tready) begin
					m_tvalid <= 1'b0;
					state_q  <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ----- sv/lobm_scan.sv -----
`timescale 1ns / 1ps
// Level scan unit: steps a price pointer one level per cycle until a
// nonempty level or the book edge. No dependencies.
module lobm_scan #(
	parameter int unsigned PW = 13
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          down,
	input  logic [PW-1:0] from,
	input  logic          level_empty,  // count read at the address of the cycle before
	input  logic [PW-1:0] edge_val,
	output logic [PW-1:0] addr,
	output logic [PW-1:0] cur,
	output logic          busy
);
	logic [PW-1:0] addr_q;
	logic [PW-1:0] chk_q;
	logic [PW-1:0] cur_q;
	logic          chk_v_q;
	logic          busy_q;

	assign addr = addr_q;
	assign cur  = cur_q;
	assign busy = busy_q;

	// addr_q is read this cycle; chk_q is the level whose count arrives now
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			addr_q  <= '0;
			chk_q   <= '0;
			chk_v_q <= 1'b0;
			cur_q   <= '0;
		end else if (start) begin
			busy_q  <= 1'b1;
			addr_q  <= from;
			chk_v_q <= 1'b0;
		end else if (busy_q) begin
			if (chk_v_q && !level_empty) begin
				busy_q <= 1'b0;
				cur_q  <= chk_q;
			end else if (addr_q == edge_val) begin
				busy_q <= 1'b0;
				cur_q  <= edge_val;
			end else begin
				chk_q   <= addr_q;
				chk_v_q <= 1'b1;
				addr_q  <= down ? addr_q - PW'(1) : addr_q + PW'(1);
			end
		end
	end
endmodule
